[rtl/core/addressable_led_line_encoder_defines.svh]
// assertion macros for the addressable led line encoder checker
// expects clk and rst_n in the scope where the macros are used
`ifndef ADDRESSABLE_LED_LINE_ENCODER_DEFINES_SVH
`define ADDRESSABLE_LED_LINE_ENCODER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define ALE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define ALE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/ale_pkg.sv]
// shared types and constants for the addressable led line encoder
// no dependencies
package ale_pkg;

    localparam int unsigned MAX_LEDS       = 1024;
    localparam int unsigned BITS_PER_PIXEL = 24;
    localparam int unsigned FRAME_LEN_W    = 11;
    localparam int unsigned COUNT_W        = 10;
    localparam int unsigned SEG_W          = 6;
    localparam int unsigned CFG_INDEX_W    = 3;
    localparam int unsigned CFG_DATA_W     = 16;

    // segment numbers within one pixel
    localparam logic [SEG_W-1:0] SEG_LAST_BIT = SEG_W'(2 * BITS_PER_PIXEL - 1);
    localparam logic [SEG_W-1:0] SEG_GAP      = SEG_W'(2 * BITS_PER_PIXEL);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_LOW   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_LOW  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LATCH_GAP = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEDS      = 3'd5;

    // effective timing and frame settings, zero values already lifted to one
    typedef struct packed {
        logic [7:0]             one_high;
        logic [7:0]             one_low;
        logic [7:0]             zero_high;
        logic [7:0]             zero_low;
        logic [15:0]            latch_gap;
        logic [FRAME_LEN_W-1:0] frame_len;
    } timing_t;

    // one classified pixel waiting for the emitter
    typedef struct packed {
        logic [BITS_PER_PIXEL-1:0] pixel;
        logic                      frame_end;
    } pixel_item_t;

endpackage

[rtl/core/addressable_led_line_encoder.sv]
// channel | handshake           | payload
// in      | in_valid / in_stall  | first_color, second_color, third_color
// out     | out_valid / out_stall| line_level, duration, is_latch_gap, last
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one segment leaves per cycle from the emitter's output register unless
// out_stall holds it; a pixel gives 48 segments, 49 if the latch gap follows.
// a two-entry queue sits between the front end and the emitter; in_stall rises
// only when it is full, and out_stall freezes the emitter with the beat held.
// reset loads the default timings, clears the pixel counter and empties the
// queue; no clearing pass, cfg_ready is always high.
// depends on ale_pkg, ale_cfg, ale_front, ale_queue, ale_back
module addressable_led_line_encoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      first_color,
    input  logic [7:0]                      second_color,
    input  logic [7:0]                      third_color,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            line_level,
    output logic [15:0]                     duration,
    output logic                            is_latch_gap,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ale_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ale_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ale_pkg::*;

    timing_t     timing;
    logic        queue_full;
    logic        queue_not_empty;
    logic        push;
    logic        pop;
    pixel_item_t push_item;
    pixel_item_t head;

    assign cfg_ready = 1'b1;

    // configuration registers
    ale_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .timing   (timing)
    );

    // pixel intake and frame tracking
    ale_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .queue_full   (queue_full),
        .first_color  (first_color),
        .second_color (second_color),
        .third_color  (third_color),
        .frame_len    (timing.frame_len),
        .in_stall     (in_stall),
        .push         (push),
        .push_item    (push_item)
    );

    // decoupling queue
    ale_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head)
    );

    // segment emitter
    ale_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (queue_not_empty),
        .item         (head),
        .timing       (timing),
        .out_stall    (out_stall),
        .pop          (pop),
        .out_valid    (out_valid),
        .line_level   (line_level),
        .duration     (duration),
        .is_latch_gap (is_latch_gap),
        .last         (last)
    );

endmodule

[rtl/core/ale_cfg.sv]
// configuration registers with reset defaults and clamping of the used values
// depends on ale_pkg
module ale_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [ale_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [ale_pkg::CFG_DATA_W-1:0]  wr_data,
    output ale_pkg::timing_t               timing
);
    import ale_pkg::*;

    logic [7:0]             one_high_reg;
    logic [7:0]             one_low_reg;
    logic [7:0]             zero_high_reg;
    logic [7:0]             zero_low_reg;
    logic [15:0]            latch_gap_reg;
    logic [FRAME_LEN_W-1:0] leds_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_high_reg  <= 8'd10;
            one_low_reg   <= 8'd7;
            zero_high_reg <= 8'd4;
            zero_low_reg  <= 8'd8;
            latch_gap_reg <= 16'd800;
            leds_reg      <= FRAME_LEN_W'(100);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_ONE_HIGH:  one_high_reg  <= wr_data[7:0];
                CFG_ONE_LOW:   one_low_reg   <= wr_data[7:0];
                CFG_ZERO_HIGH: zero_high_reg <= wr_data[7:0];
                CFG_ZERO_LOW:  zero_low_reg  <= wr_data[7:0];
                CFG_LATCH_GAP: latch_gap_reg <= wr_data[15:0];
                CFG_LEDS:      leds_reg      <= wr_data[FRAME_LEN_W-1:0];
                default:       ;
            endcase
        end
    end

    // zero durations act as one, frame length held within one to the maximum
    always_comb
    begin
        timing.one_high  = (one_high_reg  == 8'd0) ? 8'd1 : one_high_reg;
        timing.one_low   = (one_low_reg   == 8'd0) ? 8'd1 : one_low_reg;
        timing.zero_high = (zero_high_reg == 8'd0) ? 8'd1 : zero_high_reg;
        timing.zero_low  = (zero_low_reg  == 8'd0) ? 8'd1 : zero_low_reg;
        timing.latch_gap = (latch_gap_reg == 16'd0) ? 16'd1 : latch_gap_reg;
        if (leds_reg == '0)
            timing.frame_len = FRAME_LEN_W'(1);
        else if (leds_reg > FRAME_LEN_W'(MAX_LEDS))
            timing.frame_len = FRAME_LEN_W'(MAX_LEDS);
        else
            timing.frame_len = leds_reg;
    end

endmodule

[rtl/core/ale_front.sv]
// front end: takes pixel beats, tracks the frame position, marks frame ends
// depends on ale_pkg
module ale_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 queue_full,
    input  logic [7:0]                           first_color,
    input  logic [7:0]                           second_color,
    input  logic [7:0]                           third_color,
    input  logic [ale_pkg::FRAME_LEN_W-1:0]      frame_len,
    output logic                                 in_stall,
    output logic                                 push,
    output ale_pkg::pixel_item_t                 push_item
);
    import ale_pkg::*;

    logic [COUNT_W-1:0]     pixel_counter_reg;
    logic [COUNT_W-1:0]     pixel_counter_next;
    logic [FRAME_LEN_W-1:0] count_plus_one;
    logic                   frame_end;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // classify the beat against the frame length
    always_comb
    begin
        count_plus_one     = FRAME_LEN_W'(pixel_counter_reg) + FRAME_LEN_W'(1);
        frame_end          = (count_plus_one >= frame_len);
        pixel_counter_next = frame_end ? '0 : count_plus_one[COUNT_W-1:0];
        push_item.pixel     = {first_color, second_color, third_color};
        push_item.frame_end = frame_end;
    end

    // pixel counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixel_counter_reg <= '0;
        else if (push)
            pixel_counter_reg <= pixel_counter_next;
    end

endmodule

[rtl/core/ale_queue.sv]
// two-entry queue between the front end and the segment emitter
// depends on ale_pkg
module ale_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ale_pkg::pixel_item_t push_item,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output ale_pkg::pixel_item_t head
);
    import ale_pkg::*;

    pixel_item_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[rtl/core/ale_back.sv]
// back end: turns the head pixel into line segments, one per cycle unless out_stall holds the output
// depends on ale_pkg
module ale_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  ale_pkg::pixel_item_t item,
    input  ale_pkg::timing_t     timing,
    input  logic                 out_stall,
    output logic                 pop,
    output logic                 out_valid,
    output logic                 line_level,
    output logic [15:0]          duration,
    output logic                 is_latch_gap,
    output logic                 last
);
    import ale_pkg::*;

    logic [SEG_W-1:0]          seg_reg;
    logic [SEG_W-1:0]          seg_next;
    logic                      out_valid_reg;
    logic                      line_level_reg;
    logic                      line_level_next;
    logic [15:0]               duration_reg;
    logic [15:0]               duration_next;
    logic                      is_latch_gap_reg;
    logic                      is_latch_gap_next;
    logic                      last_reg;
    logic                      last_next;
    logic                      advance;
    logic                      data_bit;
    logic [BITS_PER_PIXEL-1:0] shifted;

    assign advance = !out_valid_reg || !out_stall;

    // segment decode for the current position in the pixel
    always_comb
    begin
        shifted  = item.pixel << seg_reg[SEG_W-1:1];
        data_bit = shifted[BITS_PER_PIXEL-1];
        if (seg_reg == SEG_GAP)
        begin
            line_level_next   = 1'b0;
            duration_next     = timing.latch_gap;
            is_latch_gap_next = 1'b1;
            last_next         = 1'b1;
        end
        else
        begin
            line_level_next   = !seg_reg[0];
            is_latch_gap_next = 1'b0;
            last_next         = (seg_reg == SEG_LAST_BIT) && !item.frame_end;
            case ({data_bit, seg_reg[0]})
                2'b10:   duration_next = {8'd0, timing.one_high};
                2'b11:   duration_next = {8'd0, timing.one_low};
                2'b00:   duration_next = {8'd0, timing.zero_high};
                default: duration_next = {8'd0, timing.zero_low};
            endcase
        end
        pop      = advance && item_valid && last_next;
        seg_next = last_next ? '0 : seg_reg + SEG_W'(1);
    end

    // segment counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid;
            if (item_valid)
                seg_reg <= seg_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            line_level_reg   <= line_level_next;
            duration_reg     <= duration_next;
            is_latch_gap_reg <= is_latch_gap_next;
            last_reg         <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign line_level   = line_level_reg;
    assign duration     = duration_reg;
    assign is_latch_gap = is_latch_gap_reg;
    assign last         = last_reg;

endmodule

[rtl/core/ale_checker.sv]
// port-level checks for the addressable led line encoder, bound to the top level
// depends on addressable_led_line_encoder_defines.svh
`include "addressable_led_line_encoder_defines.svh"

module ale_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  first_color,
    input logic [7:0]  second_color,
    input logic [7:0]  third_color,
    input logic        out_valid,
    input logic        out_stall,
    input logic        line_level,
    input logic [15:0] duration,
    input logic        is_latch_gap,
    input logic        last
);

    // a stalled pixel beat keeps its payload
    `ALE_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(first_color) && $stable(second_color) && $stable(third_color))

    // a held output beat stays valid and keeps its duration, line level and last flag
    `ALE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(duration) && $stable(line_level) && $stable(last))

    // the latch gap is low and closes the pixel
    `ALE_ASSERT_NOW(a_gap_shape, out_valid && is_latch_gap, !line_level && last)

    // no segment has zero length
    `ALE_ASSERT_NOW(a_dur_nonzero, out_valid, duration != 16'd0)

    // a high half of a bit is always followed at once by its low half
    `ALE_ASSERT_NEXT(a_high_then_low, out_valid && !out_stall && line_level, out_valid && !line_level && !is_latch_gap)

endmodule

bind addressable_led_line_encoder ale_checker u_checker (.*);

[sim/addressable_led_line_encoder_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for addressable_led_line_encoder: pixels in, line segments out
// depends on ale_pkg and the encoder rtl; predicts every segment and compares field by field
module addressable_led_line_encoder_tb;
    import ale_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 100;
    localparam int BATCH_PIXELS = 18;
    localparam int RANDOM_BATCHES = 17;
    localparam int LONG_FRAME_PIXELS = 16;

    // indexes outside the register map, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
    } pixel_t;

    typedef struct packed {
        logic        level;
        logic [15:0] ticks;
        logic        gap;
        logic        fin;
    } segment_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             first_color = 8'd0;
    logic [7:0]             second_color = 8'd0;
    logic [7:0]             third_color = 8'd0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   line_level;
    logic [15:0]            duration;
    logic                   is_latch_gap;
    logic                   last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_ONE_HIGH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // shadow copy of the register file and the frame position
    logic [7:0]             one_high_set = 8'd10;
    logic [7:0]             one_low_set = 8'd7;
    logic [7:0]             zero_high_set = 8'd4;
    logic [7:0]             zero_low_set = 8'd8;
    logic [15:0]            gap_set = 16'd800;
    logic [FRAME_LEN_W-1:0] frame_leds = 11'd100;
    int                     pixel_pos = 0;

    pixel_t   pixel_backlog[$];
    segment_t pending_segments[$];

    logic in_taken = 1'b0;
    int   pixels_queued = 0;
    int   pixels_taken = 0;
    int   segments_seen = 0;
    int   frames_closed = 0;
    int   mismatches = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   cycles = 0;

    addressable_led_line_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_color  (first_color),
        .second_color (second_color),
        .third_color  (third_color),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_level   (line_level),
        .duration     (duration),
        .is_latch_gap (is_latch_gap),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // a zero timing register behaves as one tick
    function automatic logic [7:0] nonzero_ticks(logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    // expected segments for one pixel, advancing the frame position
    function automatic void encode_pixel(pixel_t px);
        logic [23:0] bits;
        int          frame_len;
        bit          frame_end;
        segment_t    seg;
        int          i;
        bits = {px.first_byte, px.second_byte, px.third_byte};
        frame_len = (frame_leds == '0) ? 1 : int'(frame_leds);
        if (frame_len > int'(MAX_LEDS))
            frame_len = int'(MAX_LEDS);
        frame_end = (pixel_pos + 1 >= frame_len);
        for (i = 23; i >= 0; i--)
        begin
            seg.level = 1'b1;
            seg.ticks = {8'd0, bits[i] ? nonzero_ticks(one_high_set)
                                       : nonzero_ticks(zero_high_set)};
            seg.gap   = 1'b0;
            seg.fin   = 1'b0;
            pending_segments.push_back(seg);
            seg.level = 1'b0;
            seg.ticks = {8'd0, bits[i] ? nonzero_ticks(one_low_set)
                                       : nonzero_ticks(zero_low_set)};
            seg.fin   = (i == 0) && !frame_end;
            pending_segments.push_back(seg);
        end
        if (frame_end)
        begin
            seg.level = 1'b0;
            seg.ticks = (gap_set == 16'd0) ? 16'd1 : gap_set;
            seg.gap   = 1'b1;
            seg.fin   = 1'b1;
            pending_segments.push_back(seg);
            pixel_pos = 0;
            frames_closed++;
        end
        else
        begin
            pixel_pos = pixel_pos + 1;
        end
    endfunction

    // register writes, result check and pixel prediction on each rising edge
    always @(posedge clk)
    begin : monitor
        segment_t got;
        segment_t want;
        if (rst_n)
        begin
            // register write beat
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ONE_HIGH:  one_high_set = cfg_data[7:0];
                    CFG_ONE_LOW:   one_low_set = cfg_data[7:0];
                    CFG_ZERO_HIGH: zero_high_set = cfg_data[7:0];
                    CFG_ZERO_LOW:  zero_low_set = cfg_data[7:0];
                    CFG_LATCH_GAP: gap_set = cfg_data;
                    CFG_LEDS:      frame_leds = cfg_data[FRAME_LEN_W-1:0];
                    default:       ;
                endcase
            end
            // result beat against the oldest expectation
            if (out_valid && !out_stall)
            begin
                got = {line_level, duration, is_latch_gap, last};
                segments_seen++;
                if (pending_segments.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("segment %0d not expected: level %0b ticks %0d gap %0b last %0b",
                                 segments_seen, got.level, got.ticks, got.gap, got.fin);
                end
                else
                begin
                    want = pending_segments.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"segment %0d: expected level %0b ticks %0d gap %0b ",
                                      "last %0b, got level %0b ticks %0d gap %0b last %0b"},
                                     segments_seen, want.level, want.ticks, want.gap,
                                     want.fin, got.level, got.ticks, got.gap, got.fin);
                    end
                end
            end
            // pixel beat
            if (in_valid && !in_stall)
            begin
                encode_pixel({first_color, second_color, third_color});
                pixels_taken++;
            end
        end
        in_taken <= rst_n && in_valid && !in_stall;
    end

    // pixel driver, fed from the backlog
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                {first_color, second_color, third_color} <= pixel_backlog.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // one register write beat; valid stays up for a following write
    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [15:0] one_hi, logic [15:0] one_lo, logic [15:0] zero_hi,
                             logic [15:0] zero_lo, logic [15:0] gap, logic [15:0] leds);
        write_register(CFG_ONE_HIGH, one_hi);
        write_register(CFG_ONE_LOW, one_lo);
        write_register(CFG_ZERO_HIGH, zero_hi);
        write_register(CFG_ZERO_LOW, zero_lo);
        write_register(CFG_LATCH_GAP, gap);
        write_register(CFG_LEDS, leds);
        end_writes();
    endtask

    // bit timing picked with weight on the edges, upper data bits are junk
    function automatic logic [15:0] random_ticks();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd255;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic configure_random();
        logic [15:0] gap;
        logic [15:0] leds;
        case ($urandom_range(0, 5))
            0:       gap = 16'd0;
            1:       gap = 16'd1;
            2:       gap = 16'hFFFF;
            3:       gap = 16'($urandom);
            default: gap = 16'($urandom_range(2, 2000));
        endcase
        case ($urandom_range(0, 7))
            0:       leds = 16'd0;
            1:       leds = 16'($urandom);
            2:       leds = 16'($urandom_range(7, 30));
            default: leds = 16'($urandom_range(1, 6));
        endcase
        write_register(CFG_ONE_HIGH, random_ticks());
        write_register(CFG_ONE_LOW, random_ticks());
        write_register(CFG_ZERO_HIGH, random_ticks());
        write_register(CFG_ZERO_LOW, random_ticks());
        write_register(CFG_LATCH_GAP, gap);
        // leave the frame length alone now and then so frames span batches
        if ($urandom_range(0, 3) != 0)
            write_register(CFG_LEDS, leds);
        if ($urandom_range(0, 3) == 0)
            write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
        end_writes();
    endtask

    // backlog pushes happen just after a rising edge, away from the driver
    task automatic queue_pixel(logic [23:0] bits);
        pixel_backlog.push_back(pixel_t'(bits));
        pixels_queued++;
    endtask

    task automatic queue_random(int n);
        int k;
        for (k = 0; k < n; k++)
            queue_pixel(24'($urandom));
    endtask

    // wait until every pixel is in and every segment is out
    task automatic drain();
        do
            @(negedge clk);
        while (pixels_taken != pixels_queued || pending_segments.size() != 0);
    endtask

    initial
    begin
        int b;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset timings, field extremes and single-bit ends
        @(posedge clk);
        queue_pixel(24'h000000);
        queue_pixel(24'hFFFFFF);
        queue_pixel(24'h800001);
        queue_pixel(24'h7FFFFE);
        drain();

        // writes to unused indexes leave the map untouched
        write_register(CFG_SPARE_A, 16'hFFFF);
        write_register(CFG_SPARE_B, 16'h0001);
        end_writes();
        @(posedge clk);
        queue_pixel(24'hA5A55A);
        drain();

        // zero durations and a zero frame length: a gap after every pixel
        configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        @(posedge clk);
        queue_pixel(24'h0F0F0F);
        queue_pixel(24'hF0F0F0);
        drain();

        // largest timings, upper data bits dropped, three-pixel frame
        configure(16'hFFFF, 16'd255, 16'd1, 16'hFF01, 16'hFFFF, 16'hF803);
        @(posedge clk);
        queue_pixel(24'h55AA55);
        queue_pixel(24'hAA55AA);
        queue_pixel(24'h123456);
        drain();

        // frame length cut below the running count ends the frame next pixel
        configure(16'd1, 16'd255, 16'd255, 16'd1, 16'd1, 16'd100);
        @(posedge clk);
        queue_random(5);
        drain();
        write_register(CFG_LEDS, 16'd3);
        end_writes();
        @(posedge clk);
        queue_pixel(24'hC3C3C3);
        drain();

        // receiver holds off while pixels keep coming, input must back up
        configure(16'd9, 16'd3, 16'd2, 16'd11, 16'd40, 16'd5);
        @(posedge clk);
        hold_requests = hold_requests + 1;
        queue_random(12);
        drain();

        // oversized frame length saturates, a long run with no gap
        configure(16'd6, 16'd2, 16'd2, 16'd6, 16'd500, 16'd2047);
        @(posedge clk);
        queue_random(LONG_FRAME_PIXELS);
        drain();

        // random batches, each with its own settings and idling mix
        for (b = 0; b < RANDOM_BATCHES; b++)
        begin
            configure_random();
            @(posedge clk);
            case (b % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 52; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 52; end
                default: begin send_idle_pct = 36; stall_pct = 36; end
            endcase
            queue_random(BATCH_PIXELS);
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        $display("encoded %0d pixels into %0d segments, %0d frames closed",
                 pixels_taken, segments_seen, frames_closed);
        $display("covered zero and extreme timings, spare indexes, saturated and cut frames");
        if (mismatches == 0 && pending_segments.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[addressable_led_line_encoder.f]
+incdir+rtl/core
rtl/core/ale_pkg.sv
rtl/core/ale_cfg.sv
rtl/core/ale_front.sv
rtl/core/ale_queue.sv
rtl/core/ale_back.sv
rtl/core/addressable_led_line_encoder.sv
rtl/core/ale_checker.sv
sim/addressable_led_line_encoder_tb.sv
